@@ hw/rtl/multilevel_feedback_queue_scheduler_defines.svh @@
// Assertion macros shared by the scheduler checker.
// No dependencies.
`ifndef MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_DEFINES_SVH
`define MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_DEFINES_SVH
// Concurrent assertion on one clock, disabled in reset.
`define MFQ_ASSERT(lbl, clk_s, rst_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);
// Assertion that also runs during reset.
`define MFQ_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) prop) else $error(msg);
`endif

@@ hw/rtl/mfqs_pkg.sv @@
// Package for the feedback-queue scheduler: widths, status codes, queue records.
// No dependencies.
`default_nettype none
package mfqs_pkg;
    localparam int DEF_LEVELS = 5;
    localparam int DEF_SLOTS = 64;
    localparam int NUM_QUANTA = 5;
    localparam int CFG_IDX_W = 3;
    localparam logic [2:0] ST_QUEUED = 3'd0;
    localparam logic [2:0] ST_DROPPED = 3'd1;
    localparam logic [2:0] ST_DEMOTED = 3'd2;
    localparam logic [2:0] ST_FINISHED = 3'd3;
    localparam logic [2:0] ST_IDLE = 3'd4;
    localparam logic OP_ARRIVE = 1'b0;
    localparam logic OP_DISPATCH = 1'b1;
    localparam logic [31:0] QUANTUM_RESET [NUM_QUANTA] =
        '{32'd500000, 32'd1000000, 32'd1500000, 32'd2000000, 32'd2500000};

    typedef struct packed {
        logic        opcode;
        logic [7:0]  job_id;
        logic [31:0] run_time;
        logic [31:0] deadline;
        logic [31:0] now;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  served_id;
        logic [2:0]  served_level;
        logic [31:0] slice_length;
        logic [31:0] remaining_after;
        logic        met_deadline;
        logic [31:0] context_changes;
    } res_t;
endpackage
`default_nettype wire

@@ hw/rtl/mfqs_ram.sv @@
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
`default_nettype none
module mfqs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ hw/rtl/mfqs_front.sv @@
// Front end: input queue stage that takes commands and holds them for the engine.
// Depends on mfqs_pkg.
`default_nettype none
module mfqs_front
    import mfqs_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    output logic      full,
    input  wire cmd_t cmd_in,
    output logic      cmd_valid,
    input  wire logic cmd_take,
    output cmd_t      cmd_out
);
    // Two-entry queue between front and back.
    cmd_t slot_reg [2];
    logic rd_ptr_reg, rd_ptr_next, wr_ptr_reg, wr_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic do_push, do_pop;

    assign full = (cnt_reg == 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd_out = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop = cmd_take && cmd_valid;

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        wr_ptr_next = wr_ptr_reg ^ do_push;
        cnt_next = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/mfqs_back.sv @@
// Back end: level bookkeeping, slot memory, slice arithmetic and result register.
// Depends on mfqs_pkg and mfqs_ram.
`default_nettype none
module mfqs_back
    import mfqs_pkg::*;
#(
    parameter int LEVELS = DEF_LEVELS,
    parameter int SLOTS_PER_LEVEL = DEF_SLOTS
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cmd_valid,
    input  wire cmd_t                 cmd,
    output logic                      cmd_take,
    input  wire logic [31:0]          quantum [NUM_QUANTA],
    output logic                      res_valid,
    input  wire logic                 res_take,
    output res_t                      res
);
    localparam int LW = $clog2(LEVELS);
    localparam int SW = $clog2(SLOTS_PER_LEVEL);
    localparam int CW = $clog2(SLOTS_PER_LEVEL + 1);
    localparam int AW = $clog2(LEVELS * SLOTS_PER_LEVEL);
    localparam int DEPTH = LEVELS * SLOTS_PER_LEVEL;
    localparam int MW = 72;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_EXEC = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic [SW-1:0] head_reg [LEVELS];
    logic [CW-1:0] count_reg [LEVELS];
    logic [LW-1:0] sweep_reg;
    logic [31:0]   changes_reg;
    logic [LW-1:0] lvl_reg;
    logic [31:0]   now_reg;
    logic [AW-1:0] addr_reg;
    logic          out_full_reg;
    res_t          res_reg;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [MW-1:0] wdata, rdata;

    mfqs_ram #(.WIDTH(MW), .DEPTH(DEPTH)) u_slots (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    function automatic logic [AW-1:0] slot_addr(input logic [LW-1:0] l,
                                                input logic [SW-1:0] p);
        slot_addr = AW'(AW'(l) * AW'(SLOTS_PER_LEVEL) + AW'(p));
    endfunction

    function automatic logic [LW-1:0] lvl_inc(input logic [LW-1:0] l);
        lvl_inc = (32'(l) + 1 >= LEVELS) ? '0 : LW'(32'(l) + 1);
    endfunction

    // Ring position an offset past the head, wrapping at the level size.
    function automatic logic [SW-1:0] ring_pos(input logic [SW-1:0] h,
                                               input logic [CW-1:0] o);
        logic [31:0] s;
        s = 32'(h) + 32'(o);
        ring_pos = (s >= 32'(SLOTS_PER_LEVEL)) ? SW'(s - 32'(SLOTS_PER_LEVEL)) : SW'(s);
    endfunction

    // Search levels from the sweep point, wrapping.
    logic          found;
    logic [LW-1:0] pick;
    always_comb
    begin
        logic [LW-1:0] c;
        found = 1'b0;
        pick = '0;
        c = sweep_reg;
        for (int k = 0; k < LEVELS; k++)
        begin
            if (!found && count_reg[c] != '0)
            begin
                found = 1'b1;
                pick = c;
            end
            c = lvl_inc(c);
        end
    end

    // Slice arithmetic on the head entry.
    logic [7:0]    h_id;
    logic [31:0]   h_rem, h_dl, q, slice, left;
    logic [LW-1:0] dest;
    logic [32:0]   fin_end;
    always_comb
    begin
        h_id = rdata[71:64];
        h_rem = rdata[63:32];
        h_dl = rdata[31:0];
        q = (32'(lvl_reg) < NUM_QUANTA) ? quantum[32'(lvl_reg)] : quantum[NUM_QUANTA-1];
        slice = (h_rem < q) ? h_rem : q;
        left = h_rem - slice;
        dest = (32'(lvl_reg) + 1 < LEVELS) ? LW'(32'(lvl_reg) + 1) : lvl_reg;
        if (count_reg[dest] >= CW'(SLOTS_PER_LEVEL))
        begin
            dest = lvl_reg;
        end
        fin_end = {1'b0, now_reg} + {1'b0, slice};
    end

    logic out_free;
    logic out_set;
    assign out_free = !out_full_reg || res_take;
    assign res_valid = out_full_reg;
    assign res = res_reg;
    assign cmd_take = (state_reg == S_IDLE) && cmd_valid && out_free;
    assign out_set = (cmd_take && (cmd.opcode == OP_ARRIVE || !found))
                     || (state_reg == S_EXEC && out_free);

    always_comb
    begin
        state_next = state_reg;
        we = 1'b0;
        waddr = slot_addr('0, ring_pos(head_reg[0], count_reg[0]));
        wdata = {cmd.job_id, cmd.run_time, cmd.deadline};
        raddr = slot_addr(pick, head_reg[pick]);
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_take)
                begin
                    if (cmd.opcode == OP_ARRIVE)
                    begin
                        we = (count_reg[0] < CW'(SLOTS_PER_LEVEL));
                    end
                    else if (found)
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                // Hold the read on the popped entry.
                raddr = addr_reg;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                    waddr = slot_addr(dest, ring_pos(head_reg[dest], count_reg[dest]));
                    wdata = {h_id, left, h_dl};
                    we = (left != '0);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            lvl_reg <= pick;
            now_reg <= cmd.now;
            addr_reg <= raddr;
            if (cmd.opcode == OP_ARRIVE)
            begin
                res_reg <= '{status: (count_reg[0] < CW'(SLOTS_PER_LEVEL)) ? ST_QUEUED
                                                                          : ST_DROPPED,
                             served_id: cmd.job_id, served_level: 3'd0,
                             slice_length: 32'd0, remaining_after: cmd.run_time,
                             met_deadline: 1'b0, context_changes: changes_reg};
            end
            else
            begin
                res_reg <= '{status: ST_IDLE, served_id: 8'd0, served_level: 3'd0,
                             slice_length: 32'd0, remaining_after: 32'd0,
                             met_deadline: 1'b0, context_changes: changes_reg};
            end
        end
        else if (state_reg == S_EXEC && out_free)
        begin
            res_reg <= '{status: (left != '0) ? ST_DEMOTED : ST_FINISHED,
                         served_id: h_id, served_level: 3'(lvl_reg),
                         slice_length: slice, remaining_after: left,
                         met_deadline: (left == '0) && (fin_end <= {1'b0, h_dl}),
                         context_changes: (left != '0) ? changes_reg + 32'd1
                                                       : changes_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            for (int i = 0; i < LEVELS; i++)
            begin
                head_reg[i] <= '0;
                count_reg[i] <= '0;
            end
            sweep_reg <= '0;
            changes_reg <= '0;
            out_full_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_full_reg <= out_set || (out_full_reg && !res_take);
            if (cmd_take)
            begin
                if (cmd.opcode == OP_ARRIVE)
                begin
                    if (count_reg[0] < CW'(SLOTS_PER_LEVEL))
                    begin
                        count_reg[0] <= count_reg[0] + CW'(1);
                    end
                end
                else if (found)
                begin
                    // Pop the head now; the entry is already addressed.
                    head_reg[pick] <= ring_pos(head_reg[pick], CW'(1));
                    count_reg[pick] <= count_reg[pick] - CW'(1);
                end
            end
            else if (state_reg == S_EXEC && out_free)
            begin
                sweep_reg <= lvl_inc(lvl_reg);
                if (left != '0)
                begin
                    changes_reg <= changes_reg + 32'd1;
                    count_reg[dest] <= count_reg[dest] + CW'(1);
                end
            end
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/multilevel_feedback_queue_scheduler.sv @@
// Path: an arrive or idle dispatch passes the queue stage and the result register;
// a dispatch that serves a job passes queue stage, memory read, slice compute, result.
// Throughput: one arrive or idle dispatch per cycle while results are popped;
// a served dispatch holds the engine through its read and execute states, set by
// the registered read of the slot memory and the slice compute.
// Reset: rst_n async low clears level heads/counts, sweep, counter and queues;
// quanta return to their defaults; slot memory is not cleared.
`default_nettype none
module multilevel_feedback_queue_scheduler
    import mfqs_pkg::*;
#(
    parameter int LEVELS = DEF_LEVELS,
    parameter int SLOTS_PER_LEVEL = DEF_SLOTS
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // Command side
    input  wire logic                 push,
    output logic                      full,
    input  wire logic                 opcode,
    input  wire logic [7:0]           job_id,
    input  wire logic [31:0]          run_time,
    input  wire logic [31:0]          deadline,
    input  wire logic [31:0]          now,
    // Result side
    output logic                      empty,
    input  wire logic                 pop,
    output logic [2:0]                status,
    output logic [7:0]                served_id,
    output logic [2:0]                served_level,
    output logic [31:0]               slice_length,
    output logic [31:0]               remaining_after,
    output logic                      met_deadline,
    output logic [31:0]               context_changes,
    // Configuration writes
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data
);
    cmd_t cmd_in, cmd_q;
    res_t res;
    logic cmd_valid, cmd_take, res_valid;
    logic [31:0] quantum_reg [NUM_QUANTA];

    assign cmd_in = '{opcode: opcode, job_id: job_id, run_time: run_time,
                      deadline: deadline, now: now};

    // Quantum registers; indexes past the list are accepted and dropped.
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_QUANTA; i++)
            begin
                quantum_reg[i] <= QUANTUM_RESET[i];
            end
        end
        else if (cfg_valid && 32'(cfg_index) < NUM_QUANTA)
        begin
            quantum_reg[32'(cfg_index)] <= cfg_data;
        end
    end

    mfqs_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .cmd_in(cmd_in),
        .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd_out(cmd_q)
    );

    mfqs_back #(.LEVELS(LEVELS), .SLOTS_PER_LEVEL(SLOTS_PER_LEVEL)) u_back (
        .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd(cmd_q),
        .cmd_take(cmd_take), .quantum(quantum_reg), .res_valid(res_valid),
        .res_take(pop), .res(res)
    );

    // Result register drives the ports directly.
    assign empty = !res_valid;
    assign status = res.status;
    assign served_id = res.served_id;
    assign served_level = res.served_level;
    assign slice_length = res.slice_length;
    assign remaining_after = res.remaining_after;
    assign met_deadline = res.met_deadline;
    assign context_changes = res.context_changes;
endmodule
`default_nettype wire

@@ hw/rtl/mfqs_checker.sv @@
// Port-level checker for the scheduler, bound to the top level.
// Depends on mfqs_pkg and the defines header.
`default_nettype none
`include "multilevel_feedback_queue_scheduler_defines.svh"
module mfqs_checker
    import mfqs_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [2:0]  status,
    input wire logic [31:0] slice_length,
    input wire logic [31:0] remaining_after,
    input wire logic        met_deadline,
    input wire logic [31:0] context_changes
);
    `MFQ_ASSERT(a_status_range, clk, rst_n, !empty |-> status <= ST_IDLE, "bad status")
    `MFQ_ASSERT(a_met_only_finished, clk, rst_n, (!empty && met_deadline) |-> status == ST_FINISHED, "met_deadline off finish")
    `MFQ_ASSERT(a_demote_left, clk, rst_n, (!empty && status == ST_DEMOTED) |-> remaining_after != 32'd0, "demote with no work")
    `MFQ_ASSERT(a_hold, clk, rst_n, (!empty && !pop) |=> (!empty && $stable(context_changes) && $stable(slice_length)), "result changed while stalled")
    `MFQ_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> empty, "result during reset")
endmodule

bind multilevel_feedback_queue_scheduler mfqs_checker u_chk (
    .clk(clk), .rst_n(rst_n), .empty(empty), .pop(pop), .status(status),
    .slice_length(slice_length), .remaining_after(remaining_after),
    .met_deadline(met_deadline), .context_changes(context_changes)
);
`default_nettype wire
